// File: src/dt2ep_pkg.sv
// Shared constants, types and helper functions for the date/time to epoch converter.
// No dependencies; every other file in src uses this package.
package dt2ep_pkg;

    localparam int unsigned TEXT_W  = 48;
    localparam int unsigned PAIR_W  = 16;
    localparam int unsigned VAL_W   = 7;    // decoded pair, 0..99
    localparam int unsigned DAYS_W  = 16;   // day count since 2000, max 36593
    localparam int unsigned HMS_W   = 19;   // hour/minute/second seconds, max 362439
    localparam int unsigned SECS_W  = 32;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [SECS_W-1:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [11:0]       SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]        SECS_PER_MIN  = 6'd60;
    localparam logic [8:0]        DAYS_PER_YEAR = 9'd365;

    // 1970-to-2000 offset less one day; the day term counts days without the "-1"
    localparam logic [SECS_W-1:0] EPOCH_OFFSET = 32'd946684800 - 32'd86400;

    typedef struct packed {
        logic [DAYS_W-1:0] day_count;
        logic [HMS_W-1:0]  hms_secs;
        logic              digit_bad;
        logic              range_bad;
    } terms_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // days before the first of month index 0..11 in a common year
    function automatic logic [8:0] days_before_month(input logic [3:0] mi);
        logic [8:0] d;
        unique case (mi)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// File: src/dt2ep_in_if.sv
// Input channel: valid/ready handshake carrying the date and time text.
// Depends on dt2ep_pkg.
interface dt2ep_in_if;
    logic                          valid;
    logic                          ready;
    logic [dt2ep_pkg::TEXT_W-1:0]  date_text;
    logic [dt2ep_pkg::TEXT_W-1:0]  time_text;

    modport source (output valid, output date_text, output time_text, input ready);
    modport sink   (input valid, input date_text, input time_text, output ready);
endinterface

// File: src/dt2ep_out_if.sv
// Output channel: valid/ready handshake carrying the epoch seconds and flags.
// Depends on dt2ep_pkg.
interface dt2ep_out_if;
    logic                          valid;
    logic                          ready;
    logic [dt2ep_pkg::SECS_W-1:0]  epoch_seconds;
    logic                          digit_error;
    logic                          range_error;
    logic                          result_ok;

    modport source (output valid, output epoch_seconds, output digit_error,
                    output range_error, output result_ok, input ready);
    modport sink   (input valid, input epoch_seconds, input digit_error,
                    input range_error, input result_ok, output ready);
endinterface

// File: src/dt2ep_pair_decode.sv
// Decodes one two-character ASCII pair into a value 0..99, atoi style.
// Depends on dt2ep_pkg.
module dt2ep_pair_decode (
    input  logic [dt2ep_pkg::PAIR_W-1:0] pair,
    output logic [dt2ep_pkg::VAL_W-1:0]  value,
    output logic                         bad
);
    localparam int unsigned VAL_W = dt2ep_pkg::VAL_W;

    logic [7:0] hi_char;
    logic [7:0] lo_char;
    logic [3:0] hi_dig;
    logic [3:0] lo_dig;
    logic       hi_ok;
    logic       lo_ok;

    assign hi_char = pair[15:8];
    assign lo_char = pair[7:0];
    assign hi_ok   = dt2ep_pkg::is_digit(hi_char);
    assign lo_ok   = dt2ep_pkg::is_digit(lo_char);
    assign hi_dig  = 4'(hi_char - dt2ep_pkg::CHAR_ZERO);
    assign lo_dig  = 4'(lo_char - dt2ep_pkg::CHAR_ZERO);
    assign bad     = !hi_ok || !lo_ok;

    always_comb
    begin
        priority if (!hi_ok)
        begin
            value = '0;
        end
        else if (!lo_ok)
        begin
            value = VAL_W'(hi_dig);
        end
        else
        begin
            value = VAL_W'(hi_dig) * 7'd10 + VAL_W'(lo_dig);
        end
    end

endmodule

// File: src/dt2ep_terms.sv
// Turns the twelve text characters into a day count and a time-of-day seconds term.
// Depends on dt2ep_pkg and dt2ep_pair_decode.
module dt2ep_terms (
    input  logic [dt2ep_pkg::TEXT_W-1:0] date_text,
    input  logic [dt2ep_pkg::TEXT_W-1:0] time_text,
    output dt2ep_pkg::terms_t            terms
);
    localparam int unsigned DAYS_W = dt2ep_pkg::DAYS_W;
    localparam int unsigned HMS_W  = dt2ep_pkg::HMS_W;

    logic [dt2ep_pkg::VAL_W-1:0] day_val;
    logic [dt2ep_pkg::VAL_W-1:0] month_val;
    logic [dt2ep_pkg::VAL_W-1:0] year_val;
    logic [dt2ep_pkg::VAL_W-1:0] hour_val;
    logic [dt2ep_pkg::VAL_W-1:0] min_val;
    logic [dt2ep_pkg::VAL_W-1:0] sec_val;
    logic [5:0]                  bad;
    logic                        range_bad;
    logic [3:0]                  month_idx;
    logic [4:0]                  leap_days;
    logic                        leap_adj;
    logic [dt2ep_pkg::DAYS_W-1:0] year_days;

    dt2ep_pair_decode u_day   (.pair(date_text[47:32]), .value(day_val),   .bad(bad[0]));
    dt2ep_pair_decode u_month (.pair(date_text[31:16]), .value(month_val), .bad(bad[1]));
    dt2ep_pair_decode u_year  (.pair(date_text[15:0]),  .value(year_val),  .bad(bad[2]));
    dt2ep_pair_decode u_hour  (.pair(time_text[47:32]), .value(hour_val),  .bad(bad[3]));
    dt2ep_pair_decode u_min   (.pair(time_text[31:16]), .value(min_val),   .bad(bad[4]));
    dt2ep_pair_decode u_sec   (.pair(time_text[15:0]),  .value(sec_val),   .bad(bad[5]));

    assign range_bad = (month_val == 7'd0) || (month_val > 7'd12);
    assign month_idx = 4'(month_val[3:0] - 4'd1);
    // leap days in years before this one: ceil(year / 4)
    assign leap_days = 5'((8'(year_val) + 8'd3) >> 2);
    // this year's Feb 29 once past February
    assign leap_adj  = (month_val > 7'd2) && (year_val[1:0] == 2'b00);
    assign year_days = DAYS_W'(year_val) * DAYS_W'(dt2ep_pkg::DAYS_PER_YEAR);

    always_comb
    begin
        terms.day_count = year_days
                        + DAYS_W'(leap_days)
                        + DAYS_W'(dt2ep_pkg::days_before_month(month_idx))
                        + DAYS_W'(leap_adj)
                        + DAYS_W'(day_val);
        terms.hms_secs  = HMS_W'(hour_val) * HMS_W'(dt2ep_pkg::SECS_PER_HOUR)
                        + HMS_W'(min_val) * HMS_W'(dt2ep_pkg::SECS_PER_MIN)
                        + HMS_W'(sec_val);
        terms.digit_bad = |bad;
        terms.range_bad = range_bad;
    end

endmodule

// File: src/ascii_date_time_to_epoch_seconds_top.sv
// ASCII DDMMYY / HHMMSS to Unix seconds (years 2000..2099, wrapping mod 2^32).
// Throughput one transfer per cycle while the sink is ready or the result register
// is empty, set by a four-register pipeline with a single stall enable.
// Reset (rst_n, async, active low) clears the stage valid bits only.
// Depends on dt2ep_pkg, dt2ep_in_if, dt2ep_out_if, dt2ep_terms.
module ascii_date_time_to_epoch_seconds_top (
    input  logic         clk,
    input  logic         rst_n,
    dt2ep_in_if.sink     in_ch,
    dt2ep_out_if.source  out_ch
);
    // Pipeline:
    //   s1: raw text captured
    //   s2: decoded day count and time-of-day seconds
    //   s3: day count scaled to seconds (one 16x17 constant multiply)
    //   res: final add with the epoch offset, month range mux, all-ones check
    // Every stage moves together; the whole pipe holds only when the result
    // register is full and the sink is not ready.

    logic advance;

    logic                           s1_valid_reg;
    logic [dt2ep_pkg::TEXT_W-1:0]   s1_date_reg;
    logic [dt2ep_pkg::TEXT_W-1:0]   s1_time_reg;

    dt2ep_pkg::terms_t              s1_terms;
    logic                           s2_valid_reg;
    dt2ep_pkg::terms_t              s2_terms_reg;

    logic                           s3_valid_reg;
    logic [dt2ep_pkg::SECS_W-1:0]   s3_day_secs_reg;
    logic [dt2ep_pkg::HMS_W-1:0]    s3_hms_reg;
    logic                           s3_digit_bad_reg;
    logic                           s3_range_bad_reg;

    logic                           res_valid_reg;
    logic [dt2ep_pkg::SECS_W-1:0]   res_secs_reg;
    logic                           res_digit_reg;
    logic                           res_range_reg;
    logic                           res_ok_reg;

    logic [dt2ep_pkg::SECS_W-1:0]   res_secs_next;

    assign advance     = !res_valid_reg || out_ch.ready;
    assign in_ch.ready = advance;

    // ---- stage 1: input register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_ch.valid)
        begin
            s1_date_reg <= in_ch.date_text;
            s1_time_reg <= in_ch.time_text;
        end
    end

    // ---- stage 2: character decode and day/time terms ----
    dt2ep_terms u_terms (
        .date_text (s1_date_reg),
        .time_text (s1_time_reg),
        .terms     (s1_terms)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            s2_terms_reg <= s1_terms;
        end
    end

    // ---- stage 3: days to seconds ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s2_valid_reg)
        begin
            s3_day_secs_reg  <= dt2ep_pkg::SECS_W'(s2_terms_reg.day_count)
                              * dt2ep_pkg::SECS_PER_DAY;
            s3_hms_reg       <= s2_terms_reg.hms_secs;
            s3_digit_bad_reg <= s2_terms_reg.digit_bad;
            s3_range_bad_reg <= s2_terms_reg.range_bad;
        end
    end

    // ---- result stage: offset add, bad month forces zero ----
    always_comb
    begin
        if (s3_range_bad_reg)
        begin
            res_secs_next = '0;
        end
        else
        begin
            res_secs_next = s3_day_secs_reg
                          + dt2ep_pkg::SECS_W'(s3_hms_reg)
                          + dt2ep_pkg::EPOCH_OFFSET;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s3_valid_reg)
        begin
            res_secs_reg  <= res_secs_next;
            res_digit_reg <= s3_digit_bad_reg;
            res_range_reg <= s3_range_bad_reg;
            res_ok_reg    <= (res_secs_next != '1);
        end
    end

    assign out_ch.valid         = res_valid_reg;
    assign out_ch.epoch_seconds = res_secs_reg;
    assign out_ch.digit_error   = res_digit_reg;
    assign out_ch.range_error   = res_range_reg;
    assign out_ch.result_ok     = res_ok_reg;

endmodule

// File: tb/tb_ascii_date_time_to_epoch_seconds_top.sv
// Self-checking testbench for the ASCII date/time to epoch seconds converter.
// Drives dt2ep_in_if, checks dt2ep_out_if against a local model of the conversion.
// Depends on dt2ep_pkg, dt2ep_in_if, dt2ep_out_if and ascii_date_time_to_epoch_seconds_top.
`timescale 1ns / 1ps

module tb_ascii_date_time_to_epoch_seconds_top;

    localparam int unsigned TW = dt2ep_pkg::TEXT_W;
    localparam int unsigned SW = dt2ep_pkg::SECS_W;

    localparam logic [SW-1:0] OFFSET_2000 = 32'd946684800;
    localparam logic [SW-1:0] YEAR_SECS   = 32'd31536000;
    localparam logic [SW-1:0] DAY_SECS    = 32'd86400;
    localparam logic [SW-1:0] HOUR_SECS   = 32'd3600;
    localparam logic [SW-1:0] MIN_SECS    = 32'd60;

    localparam int unsigned RANDOM_PER_PHASE = 534;
    localparam int unsigned MAX_REPORTS      = 100;
    localparam int unsigned DRAIN_CYCLES     = 8;     // pipeline is four stages deep

    typedef struct packed {
        logic [SW-1:0] epoch_seconds;
        logic          digit_error;
        logic          range_error;
        logic          result_ok;
    } epoch_result_t;

    // Holds the expected conversions in transfer order and checks each result.
    class epoch_scoreboard;
        epoch_result_t pending_q[$];
        logic [8:0]    days_before [12] = '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
                                            9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};
        int unsigned   accepted   = 0;
        int unsigned   checked    = 0;
        int unsigned   failures   = 0;
        int unsigned   digit_seen = 0;
        int unsigned   range_seen = 0;

        // atoi-style pair decode of the twelve characters, then the seconds sum
        function epoch_result_t epoch_of(logic [TW-1:0] date_text, logic [TW-1:0] time_text);
            logic [2*TW-1:0] text;
            logic [SW-1:0]   val [6];
            logic [7:0]      hi;
            logic [7:0]      lo;
            logic            hi_ok;
            logic            lo_ok;
            logic [SW-1:0]   year;
            logic [SW-1:0]   mi;
            logic [SW-1:0]   secs;
            epoch_result_t   r;
            int              p;
            text = {date_text, time_text};
            r.digit_error = 1'b0;
            for (p = 0; p < 6; p++)
            begin
                hi = text[2*TW-1 - 16*p -: 8];
                lo = text[2*TW-9 - 16*p -: 8];
                hi_ok = (hi >= "0") && (hi <= "9");
                lo_ok = (lo >= "0") && (lo <= "9");
                if (!hi_ok || !lo_ok)
                    r.digit_error = 1'b1;
                if (!hi_ok)
                    val[p] = '0;
                else if (!lo_ok)
                    val[p] = SW'(hi - "0");
                else
                    val[p] = SW'(hi - "0") * 32'd10 + SW'(lo - "0");
            end
            // val: day, month, year, hour, minute, second
            r.range_error = (val[1] < 32'd1) || (val[1] > 32'd12);
            secs = '0;
            if (!r.range_error)
            begin
                year = val[2];
                mi   = val[1] - 32'd1;
                secs = year * YEAR_SECS;
                if (year > 0)
                    secs += (((year - 32'd1) / 32'd4) + 32'd1) * DAY_SECS;
                secs += SW'(days_before[mi[3:0]]) * DAY_SECS;
                if (mi > 32'd1 && year[1:0] == 2'd0)
                    secs += DAY_SECS;
                // day zero wraps to minus one day here
                secs += (val[0] - 32'd1) * DAY_SECS;
                secs += val[3] * HOUR_SECS;
                secs += val[4] * MIN_SECS;
                secs += val[5];
                secs += OFFSET_2000;
            end
            r.epoch_seconds = secs;
            r.result_ok     = (secs != '1);
            return r;
        endfunction

        function void note_input(logic [TW-1:0] date_text, logic [TW-1:0] time_text);
            epoch_result_t e;
            e = epoch_of(date_text, time_text);
            accepted++;
            if (e.digit_error)
                digit_seen++;
            if (e.range_error)
                range_seen++;
            pending_q.push_back(e);
        endfunction

        function void check_result(epoch_result_t got);
            epoch_result_t e;
            if (pending_q.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, got %h", $time, got);
                return;
            end
            e = pending_q.pop_front();
            checked++;
            if (got != e)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                begin
                    if (got.epoch_seconds != e.epoch_seconds)
                        $display("%0t: epoch_seconds expected %0d, got %0d",
                                 $time, e.epoch_seconds, got.epoch_seconds);
                    if (got.digit_error != e.digit_error)
                        $display("%0t: digit_error expected %b, got %b",
                                 $time, e.digit_error, got.digit_error);
                    if (got.range_error != e.range_error)
                        $display("%0t: range_error expected %b, got %b",
                                 $time, e.range_error, got.range_error);
                    if (got.result_ok != e.result_ok)
                        $display("%0t: result_ok expected %b, got %b",
                                 $time, e.result_ok, got.result_ok);
                end
            end
        endfunction

        function int unsigned pending();
            return pending_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    // pacing knobs, percent of cycles spent idle / stalled
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    epoch_scoreboard sb = new;

    dt2ep_in_if  in_bus ();
    dt2ep_out_if out_bus ();

    ascii_date_time_to_epoch_seconds_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_bus),
        .out_ch (out_bus)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Everything samples at the rising edge, before the NBA updates land,
    // so both monitors see the same values the DUT flops see.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_bus.valid && in_bus.ready)
                sb.note_input(in_bus.date_text, in_bus.time_text);
            if (out_bus.valid && out_bus.ready)
                sb.check_result({out_bus.epoch_seconds, out_bus.digit_error,
                                 out_bus.range_error, out_bus.result_ok});
        end
    end

    // Receiver: ready is re-rolled every cycle; stall_pct of zero keeps it high.
    initial
    begin
        out_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Hard stop in case the pipeline hangs.
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Offers one item and returns at the edge where the transfer happens.
    // valid is left high so back-to-back items need no extra NBA.
    task automatic send_item(input logic [TW-1:0] date_text, input logic [TW-1:0] time_text);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.date_text <= date_text;
        in_bus.time_text <= time_text;
        @(posedge clk);
        while (!in_bus.ready)
            @(posedge clk);
    endtask

    function automatic logic [15:0] two_digits(int unsigned v);
        logic [7:0] tens;
        logic [7:0] ones;
        tens = dt2ep_pkg::CHAR_ZERO + 8'(v / 10);
        ones = dt2ep_pkg::CHAR_ZERO + 8'(v % 10);
        return {tens, ones};
    endfunction

    function automatic logic [7:0] non_digit_char();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        while (c >= "0" && c <= "9")
            c = 8'($urandom_range(255));
        return c;
    endfunction

    // Random item mix: mostly plausible dates, some arbitrary digit pairs
    // (day 00, month 00/13..99, hour 99 ...), some single bad characters,
    // and some raw noise so every input bit toggles.
    task automatic make_item(output logic [TW-1:0] date_text, output logic [TW-1:0] time_text);
        int unsigned pick;
        int unsigned pos;
        logic [7:0]  c;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            date_text = {16'($urandom), 32'($urandom)};
            time_text = {16'($urandom), 32'($urandom)};
        end
        else if (pick < 30)
        begin
            date_text = {two_digits($urandom_range(99)), two_digits($urandom_range(99)),
                         two_digits($urandom_range(99))};
            time_text = {two_digits($urandom_range(99)), two_digits($urandom_range(99)),
                         two_digits($urandom_range(99))};
        end
        else
        begin
            date_text = {two_digits($urandom_range(1, 31)), two_digits($urandom_range(1, 12)),
                         two_digits($urandom_range(99))};
            time_text = {two_digits($urandom_range(23)), two_digits($urandom_range(59)),
                         two_digits($urandom_range(59))};
            if (pick < 45)
            begin
                // one corrupted character anywhere in the twelve
                pos = $urandom_range(11);
                c = $urandom_range(1) ? non_digit_char() : 8'($urandom_range(255));
                if (pos < 6)
                    date_text[TW-1 - 8*pos -: 8] = c;
                else
                    time_text[TW-1 - 8*(pos-6) -: 8] = c;
            end
        end
    endtask

    task automatic run_random(input int unsigned count);
        logic [TW-1:0] d;
        logic [TW-1:0] t;
        repeat (count)
        begin
            make_item(d, t);
            send_item(d, t);
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        in_bus.valid      = 1'b0;
        in_bus.date_text  = '0;
        in_bus.time_text  = '0;
        send_idle_pct     = 16;
        recv_stall_pct    = 75;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: field extremes and the documented corner cases ---
        send_item("010100", "000000");                 // epoch of 2000-01-01
        send_item("311299", "235959");                 // last second of 2099
        send_item("290200", "120000");                 // leap day, year 2000
        send_item("010300", "000000");                 // after Feb in a leap year
        send_item("010301", "000000");                 // after Feb, common year
        send_item("010204", "000000");                 // Feb of a leap year, no extra day
        send_item("010304", "000001");                 // March of a leap year
        send_item("000100", "000000");                 // day zero steps back one day
        send_item("990199", "999999");                 // unchecked day/hour/min/sec at 99
        send_item("010000", "000000");                 // month zero
        send_item("011300", "000000");                 // month just past the table
        send_item("019999", "000000");                 // largest month digits
        send_item("01A100", "000000");                 // bad first char: month 0
        send_item("011 05", "000000");                 // bad second char: month 1
        send_item("A10105", "1x3456");                 // bad first char in day, bad in hour
        send_item({8'h2F, "10105"}, {"00000", 8'h3A}); // just outside '0' and '9'
        send_item("150607", "08:910");                 // separator inside time text
        send_item(48'h0, 48'h0);                       // all NUL bytes
        send_item('1, '1);                             // all bits set
        send_item("311298", "000000");
        // result_ok low needs 0xFFFFFFFF, which the 2000 offset puts out of reach
        // for any decodable date, so it is only ever checked high.

        // --- random, three pacing phases ---
        run_random(RANDOM_PER_PHASE);
        send_idle_pct  = 75;
        recv_stall_pct = 16;
        run_random(RANDOM_PER_PHASE);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(RANDOM_PER_PHASE);
        in_bus.valid <= 1'b0;

        // drain: wait for every expected conversion, then a few more cycles
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d conversions of %0d transfers: %0d with bad characters,",
                 sb.checked, sb.accepted, sb.digit_seen);
        $display("%0d with bad month; pacing covered sender idle, receiver stall, full rate.",
                 sb.range_seen);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
src/dt2ep_pkg.sv
src/dt2ep_in_if.sv
src/dt2ep_out_if.sv
src/dt2ep_pair_decode.sv
src/dt2ep_terms.sv
src/ascii_date_time_to_epoch_seconds_top.sv
tb/tb_ascii_date_time_to_epoch_seconds_top.sv
